// ===== sv/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg: shared types and codes for the circle raster scan unit
// Request and response beats, the command codes and the record passed from
// the scan stage to the evaluation stage.
// ----------------------------------------------------------------------------
package crs_pkg;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [7:0]  radius;
      logic        filled;
      logic [15:0] color;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic        draw;
      logic [15:0] pixel_color;
      logic        last;
   } rsp_type;

   // One scan position, squares already formed
   typedef struct packed {
      logic [15:0] col_sq;
      logic [15:0] row_sq;
      logic [15:0] lim_hi;
      logic [15:0] lim_lo;
      logic        fill;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [15:0] color;
      logic        last;
   } stage_type;

endpackage

// ===== sv/crs_scan.sv =====
// ----------------------------------------------------------------------------
// crs_scan: command store and scan position stepper
// Holds the loaded circle, walks the offsets row by row and registers one
// scan position with its squared offsets for the evaluation stage.
// ----------------------------------------------------------------------------
module crs_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_accept,
   input  crs_pkg::req_type   req_data,
   input  logic               stage_open,
   output logic               busy,
   output logic               issue,
   output logic               issue_last,
   output logic               s1_valid,
   output crs_pkg::stage_type s1_data
);

   logic               busy_ff, busy_in;
   logic [15:0]        origin_x_ff, origin_y_ff, color_ff;
   logic [7:0]         bound_ff;
   logic               fill_ff;
   logic [15:0]        lim_hi_ff, lim_lo_ff;
   logic [8:0]         col_ff, col_in, row_ff, row_in;
   logic               s1_valid_ff;
   crs_pkg::stage_type s1_ff, s1_in;

   logic               load;
   logic [7:0]         new_bound;
   logic [15:0]        new_sq;
   logic [8:0]         bound_ext, neg_bound, new_neg;
   logic [8:0]         col_abs, row_abs;
   logic               col_end, at_last;

   assign load  = req_accept && (req_data.mode == crs_pkg::CMD_LOAD);
   assign issue = req_accept && (req_data.mode == crs_pkg::CMD_ADVANCE) && busy_ff;

   // radius one scans only the centre
   assign new_bound = (req_data.radius == 8'd1) ? 8'd0 : req_data.radius;
   assign new_sq    = 16'(req_data.radius) * 16'(req_data.radius);
   assign new_neg   = 9'(~{1'b0, new_bound}) + 9'd1;

   assign bound_ext = {1'b0, bound_ff};
   assign neg_bound = ~bound_ext + 9'd1;
   assign col_abs   = col_ff[8] ? (~col_ff + 9'd1) : col_ff;
   assign row_abs   = row_ff[8] ? (~row_ff + 9'd1) : row_ff;
   assign col_end   = $signed(col_ff) >= $signed(bound_ext);
   assign at_last   = (col_ff == bound_ext) && (row_ff == bound_ext);
   assign issue_last = issue && at_last;

   always_comb begin
      busy_in = busy_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (load) begin
         busy_in = 1'b1;
         col_in  = new_neg;
         row_in  = new_neg;
      end else if (issue) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else if (col_end) begin
            col_in = neg_bound;
            row_in = row_ff + 9'd1;
         end else begin
            col_in = col_ff + 9'd1;
         end
      end
   end

   always_comb begin
      s1_in.col_sq  = 16'(col_abs[7:0]) * 16'(col_abs[7:0]);
      s1_in.row_sq  = 16'(row_abs[7:0]) * 16'(row_abs[7:0]);
      s1_in.lim_hi  = lim_hi_ff;
      s1_in.lim_lo  = lim_lo_ff;
      s1_in.fill    = fill_ff;
      s1_in.pixel_x = origin_x_ff + {{7{col_ff[8]}}, col_ff};
      s1_in.pixel_y = origin_y_ff + {{7{row_ff[8]}}, row_ff};
      s1_in.color   = color_ff;
      s1_in.last    = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         color_ff    <= '0;
         bound_ff    <= '0;
         fill_ff     <= 1'b0;
         lim_hi_ff   <= '0;
         lim_lo_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         if (load) begin
            origin_x_ff <= req_data.center_x;
            origin_y_ff <= req_data.center_y;
            color_ff    <= req_data.color;
            bound_ff    <= new_bound;
            fill_ff     <= req_data.filled;
            lim_hi_ff   <= new_sq + 16'(req_data.radius);
            lim_lo_ff   <= new_sq - 16'(req_data.radius);
         end
         if (stage_open) begin
            s1_valid_ff <= issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_open && issue) begin
         s1_ff <= s1_in;
      end
   end

   assign busy     = busy_ff;
   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_ff;

endmodule

// ===== sv/crs_eval.sv =====
// ----------------------------------------------------------------------------
// crs_eval: distance threshold and result register
// Sums the squared offsets at full width, applies the disk or ring test
// and holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module crs_eval (
   input  logic               clock,
   input  logic               reset,
   input  logic               s1_valid,
   input  crs_pkg::stage_type s1_data,
   output logic               out_open,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output crs_pkg::rsp_type   rsp_data
);

   logic             rsp_valid_ff;
   crs_pkg::rsp_type rsp_ff, rsp_in;
   logic [16:0]      dist_sq;
   logic             under_hi, over_lo;

   assign dist_sq  = 17'(s1_data.col_sq) + 17'(s1_data.row_sq);
   assign under_hi = dist_sq <= {1'b0, s1_data.lim_hi};
   assign over_lo  = dist_sq >= {1'b0, s1_data.lim_lo};

   always_comb begin
      rsp_in.pixel_x     = s1_data.pixel_x;
      rsp_in.pixel_y     = s1_data.pixel_y;
      rsp_in.draw        = s1_data.fill ? under_hi : (under_hi && over_lo);
      rsp_in.pixel_color = s1_data.color;
      rsp_in.last        = s1_data.last;
   end

   assign out_open = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= s1_valid;
      end
   end

   // hold the beat while stalled
   always_ff @(posedge clock) begin
      if (out_open && s1_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/circle_raster_scan_unit.sv =====
// ----------------------------------------------------------------------------
// circle_raster_scan_unit: circle scan generator with distance threshold
// Usage:
//   A request beat with mode load stores centre, radius, fill mode and
//   colour and produces no response. Each advance beat while a circle is
//   loaded yields one response beat for the next position of a row-major
//   scan over offsets -radius..+radius (radius one scans only the centre),
//   carrying wrapped screen coordinates, colour, draw flag and last.
//   Advance beats with no circle loaded are taken and dropped.
//   Each response is formed in the scan register, then the result register.
//   Throughput: one beat per cycle on both channels while rsp_stall is low;
//   the scan register and the result register form a two-stage pipeline.
//   When rsp_stall is high the result beat holds; if the scan register is
//   empty, one more advance beat is still taken into it before req_stall rises.
//   Reset (synchronous) clears the loaded command and empties the pipeline.
// ----------------------------------------------------------------------------
module circle_raster_scan_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  crs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output crs_pkg::rsp_type rsp_data
);

   logic               req_accept;
   logic               stage_open, out_open;
   logic               busy, issue, issue_last, s1_valid;
   crs_pkg::stage_type s1_data;

   assign stage_open = !s1_valid || out_open;
   assign req_stall  = !stage_open;
   assign req_accept = req_valid && stage_open;

   crs_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .stage_open (stage_open),
      .busy       (busy),
      .issue      (issue),
      .issue_last (issue_last),
      .s1_valid   (s1_valid),
      .s1_data    (s1_data)
   );

   crs_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data),
      .out_open  (out_open),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_load_sets_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.mode == crs_pkg::CMD_LOAD) |=> busy)
      else $error("load beat did not start a scan");

   a_idle_advance_dropped: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.mode == crs_pkg::CMD_ADVANCE) && !busy |=> !s1_valid)
      else $error("advance beat with no circle entered the pipeline");

   a_last_ends_scan: assert property (@(posedge clock) disable iff (reset)
      issue_last |=> !busy)
      else $error("scan still running after its last position");
`endif

endmodule

// ===== verif/circle_raster_scan_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_raster_scan_unit_tb: self-checking bench for the circle scan unit
// Loads circle commands and steps their scans with advance beats. A scan
// predictor tracks the loaded circle and the scan position and queues the
// pixel each advance should produce. Returned pixel beats are checked in
// order. Both channels idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module circle_raster_scan_unit_tb;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   crs_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   crs_pkg::rsp_type rsp_data;

   circle_raster_scan_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   crs_pkg::req_type command_q[$];
   crs_pkg::rsp_type pixel_q[$];
   crs_pkg::rsp_type expected_pixel;
   int      issued_cnt   = 0;
   int      accepted_cnt = 0;
   int      error_cnt    = 0;
   int      send_pct     = 0;
   int      stall_pct    = 0;

   // Scan predictor state
   logic              scanning  = 1'b0;
   logic [15:0]       org_x     = '0;
   logic [15:0]       org_y     = '0;
   logic [7:0]        rad       = '0;
   logic              fill_mode = 1'b0;
   logic [15:0]       shade     = '0;
   logic signed [8:0] off_col   = '0;
   logic signed [8:0] off_row   = '0;

   task automatic raster_predict(input crs_pkg::req_type cmd);
      int      bound;
      int      col;
      int      row;
      int      dsq;
      int      rsq;
      crs_pkg::rsp_type px;
      if (cmd.mode == crs_pkg::CMD_LOAD) begin
         org_x     = cmd.center_x;
         org_y     = cmd.center_y;
         rad       = cmd.radius;
         fill_mode = cmd.filled;
         shade     = cmd.color;
         bound     = (cmd.radius == 8'd1) ? 0 : int'(cmd.radius);
         off_col   = 9'(-bound);
         off_row   = 9'(-bound);
         scanning  = 1'b1;
      end else if (scanning) begin
         bound = (rad == 8'd1) ? 0 : int'(rad);
         col   = int'(off_col);
         row   = int'(off_row);
         dsq   = col * col + row * row;
         rsq   = int'(rad) * int'(rad);
         px.pixel_x     = org_x + 16'(col);
         px.pixel_y     = org_y + 16'(row);
         px.pixel_color = shade;
         if (fill_mode)
            px.draw = (dsq <= rsq + int'(rad));
         else
            px.draw = (dsq >= rsq - int'(rad)) && (dsq <= rsq + int'(rad));
         px.last = (col == bound) && (row == bound);
         pixel_q.push_back(px);
         if (px.last) begin
            scanning = 1'b0;
         end else if (col >= bound) begin
            off_col = 9'(-bound);
            off_row = 9'(row + 1);
         end else begin
            off_col = 9'(col + 1);
         end
      end
   endtask

   function automatic crs_pkg::req_type random_beat();
      return crs_pkg::req_type'(58'({$urandom, $urandom}));
   endfunction

   // Bias towards the screen edges so that the offsets wrap
   function automatic logic [15:0] pick_centre();
      if ($urandom_range(3) != 0)
         return 16'($urandom);
      if ($urandom_range(1) == 0)
         return 16'($urandom_range(3));
      return 16'hFFFF - 16'($urandom_range(3));
   endfunction

   function automatic crs_pkg::req_type load_beat(input logic [15:0] cx,
                                                  input logic [15:0] cy,
                                                  input logic [7:0] r, input logic f,
                                                  input logic [15:0] c);
      crs_pkg::req_type cmd;
      cmd          = random_beat();
      cmd.mode     = crs_pkg::CMD_LOAD;
      cmd.center_x = cx;
      cmd.center_y = cy;
      cmd.radius   = r;
      cmd.filled   = f;
      cmd.color    = c;
      return cmd;
   endfunction

   function automatic crs_pkg::req_type advance_beat();
      crs_pkg::req_type cmd;
      cmd      = random_beat();
      cmd.mode = crs_pkg::CMD_ADVANCE;
      return cmd;
   endfunction

   task automatic post(input crs_pkg::req_type cmd);
      command_q.push_back(cmd);
      issued_cnt++;
   endtask

   task automatic queue_random_circles(input int quota);
      int      counted;
      int      n;
      int      b;
      int      k;
      int      sel;
      crs_pkg::req_type cmd;
      counted = 0;
      while (counted < quota) begin
         if ($urandom_range(9) == 0) begin
            // noise: any mode, any fields
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
               post(random_beat());
            counted += n;
         end else begin
            cmd = load_beat(pick_centre(), pick_centre(), 8'd0, 1'($urandom), 16'($urandom));
            sel = $urandom_range(15);
            if (sel < 10)
               cmd.radius = 8'($urandom_range(4));
            else if (sel < 15)
               cmd.radius = 8'($urandom_range(5, 12));
            else
               cmd.radius = 8'($urandom_range(128, 255));
            post(cmd);
            counted++;
            b = (cmd.radius == 8'd1) ? 0 : int'(cmd.radius);
            n = (2 * b + 1) * (2 * b + 1);
            if (sel == 15)
               n = ($urandom_range(3) == 0) ? 2 * b + 1 + $urandom_range(1, 10)
                                            : $urandom_range(1, 20);
            else if ($urandom_range(7) == 0)
               n = $urandom_range(0, n - 1);
            // keep the phase near its quota
            if (n > quota - counted)
               n = quota - counted;
            for (k = 0; k < n; k++)
               post(advance_beat());
            counted += n;
            // extra advances, stray ones if the scan has already ended
            if ($urandom_range(3) == 0)
               for (k = $urandom_range(1, 3); k > 0; k--)
                  post(advance_beat());
         end
      end
   endtask

   // Request driver: accept, predict, then present the next beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            raster_predict(req_data);
            accepted_cnt++;
         end
         if (!req_valid || !req_stall) begin
            if (command_q.size() != 0 && $urandom_range(99) >= send_pct) begin
               req_data  <= command_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            error_cnt++;
            $display("%0t: unexpected pixel beat x=%h y=%h draw=%b color=%h last=%b",
                     $time, rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.draw,
                     rsp_data.pixel_color, rsp_data.last);
         end else begin
            expected_pixel = pixel_q.pop_front();
            if (rsp_data !== expected_pixel) begin
               error_cnt++;
               $display("%0t: pixel mismatch expected x=%h y=%h draw=%b color=%h last=%b",
                        $time, expected_pixel.pixel_x, expected_pixel.pixel_y,
                        expected_pixel.draw, expected_pixel.pixel_color,
                        expected_pixel.last);
               $display("%0t:                actual   x=%h y=%h draw=%b color=%h last=%b",
                        $time, rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.draw,
                        rsp_data.pixel_color, rsp_data.last);
            end
         end
      end
   end

   initial begin
      int send_plan[3];
      int stall_plan[3];
      int k;
      int ph;
      send_plan  = '{26, 73, 0};
      stall_plan = '{73, 26, 0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle advance, radius zero and one, largest radius with
      // wide corners, load over a running scan, row turn of a small ring
      post(advance_beat());
      post(load_beat(16'hFFFF, 16'hFFFF, 8'd0, 1'b0, 16'hFFFF));
      post(advance_beat());
      post(advance_beat());
      post(load_beat(16'h0000, 16'h0000, 8'd1, 1'b1, 16'h0000));
      post(advance_beat());
      post(load_beat(16'h0000, 16'hFFFF, 8'd255, 1'b1, 16'hAAAA));
      for (k = 0; k < 3; k++)
         post(advance_beat());
      post(load_beat(16'hFFFF, 16'h0000, 8'd255, 1'b0, 16'h5555));
      for (k = 0; k < 2; k++)
         post(advance_beat());
      post(load_beat(16'h0001, 16'hFFFE, 8'd2, 1'b0, 16'h1234));
      for (k = 0; k < 10; k++)
         post(advance_beat());

      for (ph = 0; ph < 3; ph++) begin
         send_pct  = send_plan[ph];
         stall_pct = stall_plan[ph];
         queue_random_circles(360);
         while (accepted_cnt != issued_cnt)
            @(posedge clock);
         // hold the sender until the pipeline has drained
         while (pixel_q.size() != 0)
            @(posedge clock);
      end
      repeat (16) @(posedge clock);
      if (error_cnt == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d pixel beats outstanding", $time, pixel_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
